/* rtl/core/u8d_pkg.sv */
// package for the utf-8 byte stream decoder
// holds the byte class masks, field widths and the state and result structs
// no dependencies
`timescale 1ns / 1ps

package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PEND_W = 2;
    localparam int DATA_W = 24;
    localparam int USER_W = 3;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    localparam logic [CP_W-1:0] QUESTION_MARK = 21'd63;

    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic [PEND_W-1:0] bytes_pending;
        logic [CP_W-1:0]   partial_value;
    } u8d_state_t;

    typedef struct packed {
        logic            char_valid;
        logic [CP_W-1:0] code_point;
        logic            bad_lead;
        logic            dropped_tail;
        logic            end_of_string;
    } u8d_result_t;

endpackage

/* rtl/core/utf8_byte_stream_decoder_core.sv */
// top level of the utf-8 byte stream decoder: input register, decode, result register
// depends on u8d_pkg and u8d_step
//
// channel   dir  tdata                      tuser                                   tlast
// s_        in   [7:0] in_byte              -                                       is_last
// m_        out  [20:0] code_point, pad 0   [0] char_valid [1] bad_lead [2] dropped  end_of_string
//
// one byte per cycle sustained while m_ does not stall; a byte passes through the input
// register, then the decode into the result register, before it shows on m_
// state updates as a byte moves from the input register to the result register
// aresetn clears the valid flags and the sequence state; stalls on m_ back up
// through both registers, and s_tready stays high while either has room
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] in_byte
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [u8d_pkg::DATA_W-1:0]  m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [u8d_pkg::USER_W-1:0]  m_tuser,   // [0] char_valid, [1] bad_lead, [2] dropped_tail
    output logic                        m_tlast
);
    import u8d_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    u8d_state_t        state_reg;
    u8d_state_t        state_next;
    u8d_result_t       result_next;
    u8d_result_t       result_reg;
    logic              out_valid_reg;
    logic              advance;

    // result register can take a new request
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    u8d_step u_step (
        .in_byte    (in_byte_reg),
        .is_last    (in_last_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(DATA_W-CP_W){1'b0}}, result_reg.code_point};
    assign m_tuser  = {result_reg.dropped_tail, result_reg.bad_lead, result_reg.char_valid};
    assign m_tlast  = result_reg.end_of_string;

endmodule

/* rtl/core/u8d_step.sv */
// per-byte decode logic: next decoder state and the result for one byte
// depends on u8d_pkg
`timescale 1ns / 1ps

module u8d_step (
    input  logic [u8d_pkg::BYTE_W-1:0] in_byte,
    input  logic                       is_last,
    input  u8d_pkg::u8d_state_t        state_cur,
    output u8d_pkg::u8d_state_t        state_next,
    output u8d_pkg::u8d_result_t       result
);
    import u8d_pkg::*;

    logic [CP_W-1:0]   merged;
    logic [PEND_W-1:0] pend_dec;

    assign merged   = {state_cur.partial_value[CP_W-7:0], in_byte[5:0]};
    assign pend_dec = state_cur.bytes_pending - PEND_ONE;

    always_comb begin
        state_next           = state_cur;
        result.char_valid    = 1'b0;
        result.code_point    = '0;
        result.bad_lead      = 1'b0;
        result.dropped_tail  = 1'b0;
        result.end_of_string = is_last;

        if (state_cur.bytes_pending == PEND_NONE) begin
            if (!in_byte[BYTE_W-1]) begin
                result.char_valid = 1'b1;
                result.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
                state_next.bytes_pending = PEND_ONE;
                state_next.partial_value = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD2_BITS};
            end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
                state_next.bytes_pending = PEND_TWO;
                state_next.partial_value = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD3_BITS};
            end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
                state_next.bytes_pending = PEND_THREE;
                state_next.partial_value = {{(CP_W-BYTE_W){1'b0}}, in_byte & LEAD4_BITS};
            end else begin
                result.char_valid = 1'b1;
                result.code_point = QUESTION_MARK;
                result.bad_lead   = 1'b1;
            end
            result.dropped_tail = is_last && (state_next.bytes_pending != PEND_NONE);
        end else begin
            state_next.bytes_pending = pend_dec;
            if (pend_dec == PEND_NONE) begin
                result.char_valid        = 1'b1;
                result.code_point        = merged;
                state_next.partial_value = '0;
            end else begin
                state_next.partial_value = merged;
                result.dropped_tail      = is_last;
            end
        end

        // end of string clears the sequence state
        if (is_last) begin
            state_next = '0;
        end
    end

endmodule

/* tb/testbench.sv */
// self-checking testbench for utf8_byte_stream_decoder_core: directed strings, then random
// strings with idle gaps, a long output stall and a drain pause; a scoreboard predicts each char
// depends on u8d_pkg and utf8_byte_stream_decoder_core
`timescale 1ns / 1ps

import u8d_pkg::*;

class utf8_scoreboard;
    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_accum;
    u8d_result_t       expected_chars[$];
    int                error_count;

    function new();
        cont_left   = PEND_NONE;
        cp_accum    = '0;
        error_count = 0;
    endfunction

    function int outstanding();
        return expected_chars.size();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch %0d at %0t: %s got 0x%0h expected 0x%0h",
                 error_count, $realtime, what, got, want);
    endtask

    // decode one accepted byte and queue the result it should produce
    function void note_byte(logic [7:0] b, logic last);
        u8d_result_t r;
        r = '0;
        r.end_of_string = last;
        if (cont_left == PEND_NONE) begin
            if (!b[7]) begin
                r.char_valid = 1'b1;
                r.code_point = CP_W'(b);
            end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                cont_left = PEND_ONE;
                cp_accum  = CP_W'(b & LEAD2_BITS);
            end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                cont_left = PEND_TWO;
                cp_accum  = CP_W'(b & LEAD3_BITS);
            end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                cont_left = PEND_THREE;
                cp_accum  = CP_W'(b & LEAD4_BITS);
            end else begin
                r.char_valid = 1'b1;
                r.code_point = QUESTION_MARK;
                r.bad_lead   = 1'b1;
            end
            if (cont_left != PEND_NONE && last)
                r.dropped_tail = 1'b1;
        end else begin
            // continuation bits are merged without checking the top two bits
            cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == PEND_NONE) begin
                r.char_valid = 1'b1;
                r.code_point = cp_accum;
                cp_accum     = '0;
            end else if (last) begin
                r.dropped_tail = 1'b1;
            end
        end
        if (last) begin
            cont_left = PEND_NONE;
            cp_accum  = '0;
        end
        expected_chars.push_back(r);
    endfunction

    task check_char(logic [DATA_W-1:0] tdata, logic [USER_W-1:0] tuser, logic tlast);
        u8d_result_t want;
        if (expected_chars.size() == 0) begin
            report("char with no byte outstanding, tdata", 32'(tdata), 32'd0);
            return;
        end
        want = expected_chars.pop_front();
        if (tuser[0] !== want.char_valid)
            report("char_valid", 32'(tuser[0]), 32'(want.char_valid));
        if (tdata[CP_W-1:0] !== want.code_point)
            report("code_point", 32'(tdata[CP_W-1:0]), 32'(want.code_point));
        if (tdata[DATA_W-1:CP_W] !== '0)
            report("tdata pad", 32'(tdata[DATA_W-1:CP_W]), 32'd0);
        if (tuser[1] !== want.bad_lead)
            report("bad_lead", 32'(tuser[1]), 32'(want.bad_lead));
        if (tuser[2] !== want.dropped_tail)
            report("dropped_tail", 32'(tuser[2]), 32'(want.dropped_tail));
        if (tlast !== want.end_of_string)
            report("end_of_string", 32'(tlast), 32'(want.end_of_string));
    endtask
endclass

module testbench;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1600;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'd0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tlast;

    logic idle_on = 1'b1;
    logic rx_hold = 1'b0;
    int   sent_bytes = 0;
    int   cycle_count = 0;

    utf8_scoreboard sb;

    utf8_byte_stream_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: check on handshake, then pick next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_char(m_tdata, m_tuser, m_tlast);
        m_tready <= !(rx_hold || (idle_on && $urandom_range(0, 99) < 11));
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_on && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
        sent_bytes++;
    endtask

    task automatic send_string(input logic [7:0] chars[$]);
        foreach (chars[i])
            send_byte(chars[i], i == chars.size() - 1);
    endtask

    // mostly well-formed sequences, some bad leads, noise and cut-off tails
    task automatic send_random_string();
        logic [7:0] chars[$];
        int kind, n_seq, n_cont, n_cut;
        n_seq = $urandom_range(1, 6);
        repeat (n_seq) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                chars.push_back({1'b0, 7'($urandom)});
            end else if (kind < 84) begin
                n_cont = (kind < 56) ? 1 : (kind < 70) ? 2 : 3;
                case (n_cont)
                    1: chars.push_back({3'b110, 5'($urandom)});
                    2: chars.push_back({4'b1110, 4'($urandom)});
                    default: chars.push_back({5'b11110, 3'($urandom)});
                endcase
                repeat (n_cont)
                    chars.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                                : {2'b10, 6'($urandom)});
            end else if (kind < 92) begin
                chars.push_back($urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                                     : {5'b11111, 3'($urandom)});
            end else begin
                chars.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 99) < 10) begin
            n_cut = $urandom_range(0, chars.size() - 1);
            repeat (n_cut) void'(chars.pop_back());
        end
        send_string(chars);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // ascii extremes, largest 2- and 4-byte values, encoded euro sign
        send_string('{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                      8'hF7, 8'hBF, 8'hBF, 8'hBF});
        // illegal leads
        send_string('{8'h80, 8'hBF, 8'hF8, 8'hFF});
        // continuation bytes with wrong top bits
        send_string('{8'hC2, 8'h41, 8'hE0, 8'hFF, 8'h00});
        // cut off on a lead, then inside a sequence
        send_string('{8'hC3});
        send_string('{8'hF0, 8'h90, 8'h80});

        while (sent_bytes < 400)
            send_random_string();

        idle_on <= 1'b0;
        while (sent_bytes < 700)
            send_random_string();
        idle_on <= 1'b1;

        fork
            hold_receiver(300);
            while (sent_bytes < 780)
                send_random_string();
        join

        drain_results();

        while (sent_bytes < ITEM_TARGET)
            send_random_string();

        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* utf8_byte_stream_decoder_core.f */
rtl/core/u8d_pkg.sv
rtl/core/u8d_step.sv
rtl/core/utf8_byte_stream_decoder_core.sv
tb/testbench.sv
